>>> rtl/kruskal_spanning_tree_engine_unit_assert.svh
// Assertion macros for the spanning tree engine.
// Included by the top level; no other dependencies.
`ifndef KRUSKAL_SPANNING_TREE_ENGINE_UNIT_ASSERT_SVH
`define KRUSKAL_SPANNING_TREE_ENGINE_UNIT_ASSERT_SVH
// check an implication on every clock edge outside reset
`define KST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// check an implication in the following cycle
`define KST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

>>> rtl/kst_pkg.sv
// Shared types and constants for the spanning tree engine.
// No dependencies.
package kst_pkg;
	localparam int MAX_EDGES_D    = 64;
	localparam int MAX_VERTICES_D = 32;
	localparam int WEIGHT_BITS_D  = 24;
	localparam int VTX_W  = 5;
	localparam int WIN_W  = 24;
	localparam logic [1:0] ST_TREE  = 2'd0;
	localparam logic [1:0] ST_CYCLE = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic FUNC_LOAD = 1'b0;

	typedef enum logic [4:0] {
		S_IDLE, S_SCAN, S_SCAN_CHK, S_STORE,
		S_SORT_OUT, S_SORT_RD, S_SORT_IN, S_SORT_CMP, S_SORT_NEXT,
		S_UF_INIT, S_EMIT_RD, S_EMIT_RD2, S_FIND_A, S_FIND_B, S_COMP_A,
		S_COMP_B, S_DECIDE, S_OUT, S_EMPTY, S_WAIT
	} state_t;
endpackage

>>> rtl/kst_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module kst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write or read one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

>>> rtl/kruskal_spanning_tree_engine_unit.sv
// A load scans the stored edges for a duplicate, ending early on one, then stores the edge
// or sets the overflow flag when full; a run sorts the edges by weight, then for each edge
// follows and compresses the parent links and emits one result, waiting on output stalls.
// An empty run emits one result. One item at a time; s_tready is low meanwhile.
// Reset: asynchronous, active low; store empty and overflow flag clear.
// Depends on kst_pkg and kst_ram; parent/rank tables are reset after each run's sort.
module kruskal_spanning_tree_engine_unit
	import kst_pkg::*;
#(
	parameter int MAX_EDGES    = MAX_EDGES_D,
	parameter int MAX_VERTICES = MAX_VERTICES_D,
	parameter int WEIGHT_BITS  = WEIGHT_BITS_D
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // vertex_a[4:0], vertex_b[9:5], edge_weight[33:10]
	input  logic        s_tuser,  // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // end_a[4:0], end_b[9:5], length[33:10], overflow[34]
	output logic [1:0]  m_tuser,  // status
	output logic        m_tlast   // last
);
	localparam int EA = $clog2(MAX_EDGES);
	localparam int CW = $clog2(MAX_EDGES + 1);
	localparam int VA = $clog2(MAX_VERTICES);
	localparam int RW = 8;
	localparam int EW = 2 * VTX_W + WEIGHT_BITS;

	state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d, i_q, i_d, j_q, j_d;
	logic          ovf_q, ovf_d, ovfr_q, ovfr_d;
	logic [VTX_W-1:0] a_q, a_d, b_q, b_d;
	logic [WEIGHT_BITS-1:0] w_q, w_d, cw_q, cw_d;
	logic [VA-1:0] ra_q, ra_d, rb_q, rb_d, v_q, v_d;
	logic [VA-1:0] parent_q [MAX_VERTICES];
	logic [RW-1:0] rank_q [MAX_VERTICES];
	logic          uf_clr, p_we, r_we;
	logic [VA-1:0] p_idx, p_val, r_idx;
	logic [RW-1:0] r_val;
	logic          e_we, o_we;
	logic [EA-1:0] e_addr, o_addr;
	logic [EW-1:0] e_wd, e_rd;
	logic [EA-1:0] o_wd, o_rd, cur_q, cur_d;
	logic          ov_q, ov_d, last_q, last_d;
	logic [36:0]   out_q, out_d;
	logic          in_acc;

	kst_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edges (
		.clk(clk), .we(e_we), .addr(e_addr), .wdata(e_wd), .rdata(e_rd));
	kst_ram #(.WIDTH(EA), .DEPTH(MAX_EDGES)) u_order (
		.clk(clk), .we(o_we), .addr(o_addr), .wdata(o_wd), .rdata(o_rd));

	logic [VTX_W-1:0] rd_a, rd_b;
	logic [WEIGHT_BITS-1:0] rd_w;
	assign rd_a = e_rd[VTX_W-1:0];
	assign rd_b = e_rd[2*VTX_W-1:VTX_W];
	assign rd_w = e_rd[EW-1:2*VTX_W];

	assign s_tready = (state_q == S_IDLE);
	assign in_acc = s_tvalid && s_tready;
	assign m_tvalid = ov_q;
	assign m_tdata = {5'b0, out_q[36], out_q[33:0]};
	assign m_tuser = out_q[35:34];
	assign m_tlast = last_q;

	// state register and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ovf_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ovf_q <= ovf_d;
			ov_q <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		i_q <= i_d; j_q <= j_d; a_q <= a_d; b_q <= b_d; w_q <= w_d; cw_q <= cw_d;
		ra_q <= ra_d; rb_q <= rb_d; v_q <= v_d; cur_q <= cur_d; ovfr_q <= ovfr_d;
		out_q <= out_d; last_q <= last_d;
	end

	// union-find tables: one parent and one rank write a cycle
	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_VERTICES; k++) begin
			if (uf_clr) begin
				parent_q[k] <= VA'(k);
				rank_q[k] <= '0;
			end
		end
		if (p_we) parent_q[p_idx] <= p_val;
		if (r_we) rank_q[r_idx] <= r_val;
	end

	// sequencer
	always_comb begin
		state_d = state_q; count_d = count_q; ovf_d = ovf_q; ovfr_d = ovfr_q;
		i_d = i_q; j_d = j_q; a_d = a_q; b_d = b_q; w_d = w_q; cw_d = cw_q;
		ra_d = ra_q; rb_d = rb_q; v_d = v_q; cur_d = cur_q;
		ov_d = ov_q; out_d = out_q; last_d = last_q;
		uf_clr = 1'b0; p_we = 1'b0; r_we = 1'b0;
		p_idx = ra_q; p_val = rb_q; r_idx = rb_q; r_val = rank_q[rb_q] + RW'(1);
		e_we = 1'b0; e_addr = i_q[EA-1:0]; e_wd = {w_q, b_q, a_q};
		o_we = 1'b0; o_addr = j_q[EA-1:0]; o_wd = cur_q;
		if (ov_q && m_tready) ov_d = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					a_d = s_tdata[4:0];
					b_d = s_tdata[9:5];
					w_d = WEIGHT_BITS'(s_tdata[33:10]);
					i_d = '0;
					ovfr_d = ovf_q;
					if (s_tuser == FUNC_LOAD) begin
						if (32'(s_tdata[4:0]) < MAX_VERTICES
								&& 32'(s_tdata[9:5]) < MAX_VERTICES)
							state_d = S_SCAN;
					end else if (count_q == '0) begin
						state_d = S_EMPTY;
					end else begin
						state_d = S_SORT_OUT;
					end
				end
			end
			S_SCAN: begin
				if (i_q == count_q) begin
					state_d = S_STORE;
				end else begin
					e_addr = i_q[EA-1:0];
					state_d = S_SCAN_CHK;
				end
			end
			S_SCAN_CHK: begin
				if ((rd_a == a_q && rd_b == b_q) || (rd_a == b_q && rd_b == a_q)) begin
					state_d = S_IDLE;
				end else begin
					i_d = i_q + CW'(1);
					state_d = S_SCAN;
				end
			end
			S_STORE: begin
				if (32'(count_q) >= MAX_EDGES) begin
					ovf_d = 1'b1;
				end else begin
					e_we = 1'b1;
					e_addr = count_q[EA-1:0];
					count_d = count_q + CW'(1);
				end
				state_d = S_IDLE;
			end
			// insertion sort of an index list; i is the edge being placed
			S_SORT_OUT: begin
				if (i_q == count_q) begin
					uf_clr = 1'b1;
					i_d = '0;
					state_d = S_EMIT_RD;
				end else begin
					e_addr = i_q[EA-1:0];
					cur_d = i_q[EA-1:0];
					j_d = i_q;
					state_d = S_SORT_RD;
				end
			end
			S_SORT_RD: begin
				cw_d = rd_w;
				state_d = S_SORT_IN;
			end
			S_SORT_IN: begin
				if (j_q == '0) begin
					o_we = 1'b1;
					state_d = S_SORT_NEXT;
				end else begin
					o_addr = EA'(j_q - CW'(1));
					state_d = S_SORT_CMP;
				end
			end
			S_SORT_CMP: begin
				// o_rd holds order[j-1]; fetch its weight and keep it on the read port
				e_addr = o_rd;
				o_addr = EA'(j_q - CW'(1));
				v_d = '0;
				state_d = S_WAIT;
			end
			S_WAIT: begin
				if (rd_w > cw_q) begin
					o_we = 1'b1;
					o_wd = o_rd;
					j_d = j_q - CW'(1);
					state_d = S_SORT_IN;
				end else begin
					o_we = 1'b1;
					state_d = S_SORT_NEXT;
				end
			end
			S_SORT_NEXT: begin
				i_d = i_q + CW'(1);
				state_d = S_SORT_OUT;
			end
			S_EMIT_RD: begin
				o_addr = i_q[EA-1:0];
				state_d = S_EMIT_RD2;
			end
			S_EMIT_RD2: begin
				e_addr = o_rd;
				state_d = S_UF_INIT;
			end
			S_UF_INIT: begin
				a_d = rd_a; b_d = rd_b; w_d = rd_w;
				ra_d = VA'(rd_a);
				state_d = S_FIND_A;
			end
			// follow parent links to the roots, one link a cycle
			S_FIND_A: begin
				if (parent_q[ra_q] != ra_q) begin
					ra_d = parent_q[ra_q];
				end else begin
					v_d = VA'(a_q);
					rb_d = VA'(b_q);
					state_d = S_COMP_A;
				end
			end
			S_COMP_A: begin
				if (parent_q[v_q] != ra_q) begin
					p_we = 1'b1; p_idx = v_q; p_val = ra_q;
					v_d = parent_q[v_q];
				end else begin
					state_d = S_FIND_B;
				end
			end
			S_FIND_B: begin
				if (parent_q[rb_q] != rb_q) begin
					rb_d = parent_q[rb_q];
				end else begin
					v_d = VA'(b_q);
					state_d = S_COMP_B;
				end
			end
			S_COMP_B: begin
				if (parent_q[v_q] != rb_q) begin
					p_we = 1'b1; p_idx = v_q; p_val = rb_q;
					v_d = parent_q[v_q];
				end else begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!ov_q || m_tready) begin
					if (ra_q == rb_q) begin
						out_d = {ovfr_q, ST_CYCLE, WIN_W'(w_q), b_q, a_q};
					end else begin
						out_d = {ovfr_q, ST_TREE, WIN_W'(w_q), b_q, a_q};
						if (rank_q[ra_q] > rank_q[rb_q]) begin
							p_we = 1'b1; p_idx = rb_q; p_val = ra_q;
						end else begin
							p_we = 1'b1; p_idx = ra_q; p_val = rb_q;
							if (rank_q[ra_q] == rank_q[rb_q] && rank_q[rb_q] != '1)
								r_we = 1'b1;
						end
					end
					last_d = (i_q + CW'(1) == count_q);
					ov_d = 1'b1;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (i_q + CW'(1) == count_q) begin
					count_d = '0;
					ovf_d = 1'b0;
					state_d = S_IDLE;
				end else begin
					i_d = i_q + CW'(1);
					state_d = S_EMIT_RD;
				end
			end
			S_EMPTY: begin
				if (!ov_q || m_tready) begin
					out_d = {ovfr_q, ST_EMPTY, WIN_W'(0), VTX_W'(0), VTX_W'(0)};
					last_d = 1'b1;
					ov_d = 1'b1;
					ovf_d = 1'b0;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

`include "kruskal_spanning_tree_engine_unit_assert.svh"
	`KST_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != S_IDLE, !s_tready)
	`KST_ASSERT_NXT(a_hold_out, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`KST_ASSERT_IMP(a_count_max, clk, arst_n, 1'b1, 32'(count_q) <= MAX_EDGES)
endmodule

>>> tb/sv/tb_kruskal_spanning_tree_engine_unit.sv
// Self-checking testbench for the Kruskal spanning tree engine.
// Predicts every run's edge list and tree/cycle marks; depends on kst_pkg and the RTL top.
`timescale 1ns / 100ps

module tb_kruskal_spanning_tree_engine_unit;
	import kst_pkg::*;

	typedef struct {
		logic [VTX_W-1:0] a;
		logic [VTX_W-1:0] b;
		logic [WIN_W-1:0] w;
	} edge_rec_t;

	typedef struct {
		logic [VTX_W-1:0] a;
		logic [VTX_W-1:0] b;
		logic [WIN_W-1:0] w;
		logic [1:0]       status;
		logic             ovf;
		logic             last;
	} mst_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	// predictor state: stored edges and the full-store flag
	edge_rec_t   stored_edges[$];
	logic        store_dropped;
	mst_result_t mst_expect_q[$];

	int error_count;
	int loads_sent;
	int runs_sent;
	int results_seen;
	int snd_idle_pct;
	int rcv_idle_pct;
	int hold_req;
	int hold_left;

	kruskal_spanning_tree_engine_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("Timeout with %0d results outstanding", mst_expect_q.size());
		$display("Verification failed");
		$finish;
	end

	// add one edge to the predicted store, skipping duplicates and flagging a full store
	function automatic void store_edge(logic [4:0] a, logic [4:0] b, logic [23:0] w);
		edge_rec_t e;
		foreach (stored_edges[i]) begin
			if ((stored_edges[i].a == a && stored_edges[i].b == b) ||
				(stored_edges[i].a == b && stored_edges[i].b == a))
				return;
		end
		if (stored_edges.size() >= MAX_EDGES_D) begin
			store_dropped = 1'b1;
			return;
		end
		e.a = a;
		e.b = b;
		e.w = w;
		stored_edges.push_back(e);
	endfunction

	function automatic int uf_root(ref int par[MAX_VERTICES_D], input int v);
		int r;
		r = v;
		while (par[r] != r) r = par[r];
		return r;
	endfunction

	// sort stably by weight, mark tree or cycle edges, and clear the store
	function automatic void predict_spanning_tree();
		int order[$];
		int par[MAX_VERTICES_D];
		int j, ra, rb, cur;
		mst_result_t r;
		if (stored_edges.size() == 0) begin
			r.a = '0;
			r.b = '0;
			r.w = '0;
			r.status = ST_EMPTY;
			r.ovf = store_dropped;
			r.last = 1'b1;
			mst_expect_q.push_back(r);
			store_dropped = 1'b0;
			return;
		end
		foreach (stored_edges[i]) begin
			order.push_back(i);
			j = i;
			while (j > 0 && stored_edges[order[j-1]].w > stored_edges[i].w) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = i;
		end
		for (int v = 0; v < MAX_VERTICES_D; v++) par[v] = v;
		for (int i = 0; i < order.size(); i++) begin
			cur = order[i];
			ra = uf_root(par, int'(stored_edges[cur].a));
			rb = uf_root(par, int'(stored_edges[cur].b));
			r.a = stored_edges[cur].a;
			r.b = stored_edges[cur].b;
			r.w = stored_edges[cur].w;
			r.ovf = store_dropped;
			r.last = (i == order.size() - 1);
			if (ra == rb) begin
				r.status = ST_CYCLE;
			end else begin
				r.status = ST_TREE;
				par[ra] = rb;
			end
			mst_expect_q.push_back(r);
		end
		stored_edges.delete();
		store_dropped = 1'b0;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		error_count++;
		$display("MISMATCH %s: got %0h expected %0h (result %0d)",
			what, got, want, results_seen);
	endtask

	// send one transfer; valid stays high into the next call unless a gap is taken
	task automatic send_item(logic func, logic [4:0] a, logic [4:0] b, logic [23:0] w);
		if ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < snd_idle_pct) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= {6'b0, w, b, a};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (func == FUNC_LOAD) begin
			store_edge(a, b, w);
			loads_sent++;
		end else begin
			predict_spanning_tree();
			runs_sent++;
		end
	endtask

	task automatic load_edge(logic [4:0] a, logic [4:0] b, logic [23:0] w);
		send_item(FUNC_LOAD, a, b, w);
	endtask

	task automatic start_run();
		send_item(~FUNC_LOAD, 5'($urandom), 5'($urandom), 24'($urandom));
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (mst_expect_q.size() != 0) @(posedge clk);
	endtask

	// receiver: random stalls, or a long hold when requested
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// compare each result transfer against the oldest prediction
	always @(posedge clk) begin
		mst_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (mst_expect_q.size() == 0) begin
				report_mismatch("unexpected result", longint'(m_tdata), longint'(0));
			end else begin
				want = mst_expect_q.pop_front();
				if (m_tdata[4:0] !== want.a)
					report_mismatch("end_a", longint'(m_tdata[4:0]), longint'(want.a));
				if (m_tdata[9:5] !== want.b)
					report_mismatch("end_b", longint'(m_tdata[9:5]), longint'(want.b));
				if (m_tdata[33:10] !== want.w)
					report_mismatch("length", longint'(m_tdata[33:10]), longint'(want.w));
				if (m_tuser !== want.status)
					report_mismatch("status", longint'(m_tuser), longint'(want.status));
				if (m_tdata[34] !== want.ovf)
					report_mismatch("overflow", longint'(m_tdata[34]), longint'(want.ovf));
				if (m_tlast !== want.last)
					report_mismatch("last", longint'(m_tlast), longint'(want.last));
			end
			results_seen++;
		end
	end

	// empty run, field extremes, duplicates, self loop, equal weights
	task automatic test_directed();
		start_run();
		load_edge(5'd0, 5'd31, 24'h000000);
		load_edge(5'd31, 5'd0, 24'hFFFFFF);
		load_edge(5'd0, 5'd31, 24'h000001);
		load_edge(5'd7, 5'd7, 24'h000002);
		load_edge(5'd1, 5'd2, 24'h000100);
		load_edge(5'd2, 5'd3, 24'h000100);
		load_edge(5'd3, 5'd1, 24'h000100);
		load_edge(5'd31, 5'd30, 24'hFFFFFF);
		load_edge(5'd30, 5'd0, 24'hAAAAAA);
		load_edge(5'd21, 5'd10, 24'h555555);
		load_edge(5'd10, 5'd21, 24'h000000);
		load_edge(5'd31, 5'd31, 24'h000000);
		start_run();
		load_edge(5'd4, 5'd9, 24'h123456);
		start_run();
		start_run();
	endtask

	// fill the store, overflow it, then check the flag clears after the run
	task automatic test_overflow();
		for (int i = 0; i < MAX_EDGES_D + 2; i++)
			load_edge(5'(i % 32), 5'((i / 32 + i + 1) % 32), 24'($urandom_range(0, 40)));
		load_edge(5'd0, 5'd1, 24'h0);
		start_run();
		start_run();
	endtask

	// long receiver hold while the sender keeps offering, then a full pause
	task automatic test_backpressure();
		hold_req = 600;
		for (int g = 0; g < 2; g++) begin
			for (int i = 0; i < 8; i++)
				load_edge(5'($urandom_range(0, 9)), 5'($urandom_range(0, 9)), 24'($urandom));
			start_run();
		end
		wait_drain();
	endtask

	// random groups of loads ended by a run; mostly small sets, often few vertices
	task automatic test_random(int n_items);
		int sent, grp, vmax, wmax;
		sent = 0;
		while (sent < n_items) begin
			grp = ($urandom_range(19) == 0) ? $urandom_range(30, 70) : $urandom_range(0, 10);
			vmax = ($urandom_range(1) == 0) ? 6 : 31;
			wmax = ($urandom_range(2) == 0) ? 4 : 24'hFFFFFF;
			for (int i = 0; i < grp; i++) begin
				load_edge(5'($urandom_range(0, vmax)), 5'($urandom_range(0, vmax)),
					24'($urandom_range(0, wmax)));
				sent++;
			end
			start_run();
			sent++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		store_dropped = 1'b0;
		error_count = 0;
		loads_sent = 0;
		runs_sent = 0;
		results_seen = 0;
		hold_req = 0;
		hold_left = 0;
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		snd_idle_pct = 38;
		rcv_idle_pct = 51;
		test_directed();
		test_overflow();
		test_backpressure();
		test_random(60);
		snd_idle_pct = 51;
		rcv_idle_pct = 38;
		test_random(60);
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		test_random(60);

		wait_drain();
		repeat (200) @(posedge clk);
		$display("Sent %0d edge loads and %0d spanning tree runs, checked %0d results",
			loads_sent, runs_sent, results_seen);
		$display("Covered empty runs, duplicates, self loops, ties, overflow and stalls");
		if (error_count == 0 && mst_expect_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/kst_pkg.sv
rtl/kst_ram.sv
rtl/kruskal_spanning_tree_engine_unit.sv
tb/sv/tb_kruskal_spanning_tree_engine_unit.sv
